@@ sv/lpe_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and constant functions of the log-normal peak evaluator.
// Used by the configuration interface, the cell modules and the top level; depends on nothing.
package lpe_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE  = 3'd0,
    REG_CENTER     = 3'd1,
    REG_WIDTH      = 3'd2,
    REG_SHAPE      = 3'd3,
    REG_BACKGROUND = 3'd4
  } cfg_reg_t;

  // Reset values of the registers
  localparam logic [31:0] AMPLITUDE_RST  = 32'h0001_0000;
  localparam logic [31:0] CENTER_RST     = 32'h0000_0000;
  localparam logic [31:0] WIDTH_RST      = 32'h0001_0000;
  localparam logic [31:0] SHAPE_RST      = 32'h0100_0000;
  localparam logic [31:0] BACKGROUND_RST = 32'h0000_0000;
  localparam logic [31:0] SHAPE_ONE      = 32'h0100_0000;

  // Division cell: partial remainder and dividend/quotient shift word
  typedef struct packed {
    logic [35:0] rem;
    logic [63:0] nq;
  } div_st_t;

  // Normalise cell: word being left-aligned and position of its leading one
  typedef struct packed {
    logic [127:0] val;
    logic [6:0]   k;
  } norm_st_t;

  // Log2 squaring cell: Q.30 mantissa and fraction bits so far
  typedef struct packed {
    logic [30:0] m;
    logic [29:0] frac;
  } sq_st_t;

  // Power-of-two cell: Q.32 factor and the exponent fraction still to consume
  typedef struct packed {
    logic [32:0] g;
    logic [31:0] f;
  } exp_st_t;

  // Side data that travels with each transaction down the pipeline
  typedef struct packed {
    logic        dneg;
    logic [55:0] t;
    logic        cut;
    logic [6:0]  k;
    logic        big;
    logic [7:0]  n;
    logic        zero;
  } tag_t;

  // Integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Factor applied by power-of-two cell j (top fraction bit first)
  function automatic logic [31:0] exp_b(input int j);
    logic [63:0] b;
    b = 64'h0000_0000_8000_0000;
    for (int i = 0; i < j; i++) begin
      b = isqrt64(b << 32);
    end
    return b[31:0];
  endfunction

endpackage

@@ sv/lpe_in_if.sv @@
`timescale 1ns / 1ps
// Input channel of the log-normal peak evaluator: one abscissa per transaction.
// Standalone; no package needed.
interface lpe_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] abscissa;

  modport source (output valid, output abscissa, input ready);
  modport sink (input valid, input abscissa, output ready);
endinterface

@@ sv/lpe_out_if.sv @@
`timescale 1ns / 1ps
// Result channel of the log-normal peak evaluator: value and parameter error flag.
// Standalone; no package needed.
interface lpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               bad_param;

  modport source (output valid, output value, output bad_param, input ready);
  modport sink (input valid, input value, input bad_param, output ready);
endinterface

@@ sv/lpe_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel of the log-normal peak evaluator.
// Depends on lpe_pkg for the index width.
interface lpe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lpe_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/lpe_div_cell.sv @@
`timescale 1ns / 1ps
// One restoring-division step: shifts in the next dividend bit, yields one quotient bit.
// Depends on lpe_pkg for the cell state type.
module lpe_div_cell (
  input  logic             clk,
  input  logic             en,
  input  logic [35:0]      divisor,
  input  lpe_pkg::div_st_t st_in,
  output lpe_pkg::div_st_t st_out
);

  logic [36:0] trial;
  logic [36:0] diff;
  logic        ge;

  // Trial subtract of the divisor from the widened remainder
  assign trial = {st_in.rem, st_in.nq[63]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  // Advance remainder and quotient
  always_ff @(posedge clk) begin
    if (en) begin
      st_out.rem <= ge ? diff[35:0] : trial[35:0];
      st_out.nq  <= {st_in.nq[62:0], ge};
    end
  end

endmodule

@@ sv/lpe_norm_cell.sv @@
`timescale 1ns / 1ps
// One step of leading-one alignment: shift left by a fixed amount if the top bits are clear.
// Depends on lpe_pkg for the cell state type.
module lpe_norm_cell (
  input  logic              clk,
  input  logic              en,
  input  logic [6:0]        shamt,
  input  lpe_pkg::norm_st_t st_in,
  output lpe_pkg::norm_st_t st_out
);

  logic [127:0] top_mask;
  logic         hit;

  assign top_mask = ~({128{1'b1}} >> shamt);
  assign hit      = (st_in.val & top_mask) == '0;

  // Shift and track the leading-one position
  always_ff @(posedge clk) begin
    if (en) begin
      st_out.val <= hit ? (st_in.val << shamt) : st_in.val;
      st_out.k   <= hit ? (st_in.k - shamt) : st_in.k;
    end
  end

endmodule

@@ sv/lpe_sq_cell.sv @@
`timescale 1ns / 1ps
// One log2 fraction bit by squaring the Q.30 mantissa.
// Depends on lpe_pkg for the cell state type.
module lpe_sq_cell (
  input  logic            clk,
  input  logic            en,
  input  lpe_pkg::sq_st_t st_in,
  output lpe_pkg::sq_st_t st_out
);

  logic [61:0] prod;
  logic [31:0] msq;

  assign prod = {31'd0, st_in.m} * {31'd0, st_in.m};
  assign msq  = prod[61:30];

  // Square; halve and emit a one when the mantissa reaches two
  always_ff @(posedge clk) begin
    if (en) begin
      st_out.m    <= msq[31] ? msq[31:1] : msq[30:0];
      st_out.frac <= {st_in.frac[28:0], msq[31]};
    end
  end

endmodule

@@ sv/lpe_exp_cell.sv @@
`timescale 1ns / 1ps
// One exponent fraction bit of 2^-q: scale the Q.32 factor when the top bit is set.
// Depends on lpe_pkg for the cell state type.
module lpe_exp_cell (
  input  logic             clk,
  input  logic             en,
  input  logic [31:0]      fac,
  input  lpe_pkg::exp_st_t st_in,
  output lpe_pkg::exp_st_t st_out
);

  logic [64:0] prod;

  assign prod = {32'd0, st_in.g} * {33'd0, fac};

  // Apply this bit's factor and move to the next bit
  always_ff @(posedge clk) begin
    if (en) begin
      st_out.g <= st_in.f[31] ? prod[64:32] : st_in.g;
      st_out.f <= {st_in.f[30:0], 1'b0};
    end
  end

endmodule

@@ sv/lognormal_peak_eval.sv @@
`timescale 1ns / 1ps
// Log-normal peak evaluator: takes one abscissa per cycle while the input is not held off or
// stalled, and returns one result per transaction, in order. The datapath is a row of one-step cells
// (a 56-cell divider for the scaled offset, a 7-cell normaliser and 30 squaring cells
// for log2, a 28-cell divider for the log ratio, 32 cells for the power of two); a stall
// on the result side freezes the whole row. After reset and after every configuration
// write the input is held off while a free-running 49-cell divider and log2 chain
// settle the terms derived from shape. Depends on lpe_pkg and the three interfaces.
module lognormal_peak_eval (
  input logic       clk,
  input logic       rst,
  lpe_in_if.sink    sample,
  lpe_out_if.source result,
  lpe_cfg_if.sink   cfg
);

  localparam int TD_N  = 56;
  localparam int PD_N  = 49;
  localparam int NM_N  = 7;
  localparam int SQ_N  = 30;
  localparam int RD_N  = 28;
  localparam int EX_N  = 32;
  localparam int S_PA  = TD_N + 1;
  localparam int S_PB  = S_PA + 1;
  localparam int S_SQ  = S_PB + NM_N + 1;
  localparam int S_LG  = S_SQ + SQ_N;
  localparam int S_RS  = S_LG + RD_N + 1;
  localparam int S_QS  = S_RS + 1;
  localparam int S_EX  = S_QS + 1;
  localparam int S_GS  = S_EX + EX_N;
  localparam int S_MS  = S_GS + 1;
  localparam int S_OUT = S_MS + 1;
  localparam int NST   = S_OUT + 1;

  localparam logic [104:0] U_ONE = 105'd1 << 48;

  // Configuration registers
  logic [31:0] amplitude;
  logic [31:0] center;
  logic [31:0] width;
  logic [31:0] shape;
  logic [31:0] background;
  logic        cfg_acc;

  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid && cfg.ready;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude  <= lpe_pkg::AMPLITUDE_RST;
      center     <= lpe_pkg::CENTER_RST;
      width      <= lpe_pkg::WIDTH_RST;
      shape      <= lpe_pkg::SHAPE_RST;
      background <= lpe_pkg::BACKGROUND_RST;
    end else if (cfg_acc) begin
      unique case (lpe_pkg::cfg_reg_t'(cfg.index))
        lpe_pkg::REG_AMPLITUDE:  amplitude  <= cfg.data;
        lpe_pkg::REG_CENTER:     center     <= cfg.data;
        lpe_pkg::REG_WIDTH:      width      <= cfg.data;
        lpe_pkg::REG_SHAPE:      shape      <= cfg.data;
        lpe_pkg::REG_BACKGROUND: background <= cfg.data;
        default: ;
      endcase
    end
  end

  // Hold off input until the shape terms have settled
  logic [6:0] prep_cnt;
  logic       prep_done;

  always_ff @(posedge clk) begin
    if (rst || cfg_acc) begin
      prep_cnt <= '0;
    end else if (!prep_cnt[6]) begin
      prep_cnt <= prep_cnt + 7'd1;
    end
  end

  assign prep_done = prep_cnt[6];

  // Shape terms: 2^48 / shape and log2 shape, free running
  lpe_pkg::div_st_t  pd_st [0:PD_N];
  lpe_pkg::norm_st_t pn_st [0:NM_N];
  lpe_pkg::sq_st_t   ps_st [0:SQ_N];

  assign pd_st[0] = '{rem: '0, nq: {1'b1, 63'd0}};
  assign pn_st[0] = '{val: {96'd0, shape}, k: 7'd127};
  assign ps_st[0] = '{m: pn_st[NM_N].val[127:97], frac: '0};

  for (genvar j = 0; j < PD_N; j++) begin : g_pdiv
    lpe_div_cell u_cell (
      .clk(clk), .en(1'b1), .divisor({4'd0, shape}), .st_in(pd_st[j]), .st_out(pd_st[j+1])
    );
  end

  for (genvar j = 0; j < NM_N; j++) begin : g_pnorm
    localparam logic [6:0] SH = 7'(64 >> j);
    lpe_norm_cell u_cell (
      .clk(clk), .en(1'b1), .shamt(SH), .st_in(pn_st[j]), .st_out(pn_st[j+1])
    );
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_psq
    lpe_sq_cell u_cell (.clk(clk), .en(1'b1), .st_in(ps_st[j]), .st_out(ps_st[j+1]));
  end

  logic [48:0]        inv_c;
  logic               rneg_c;
  logic signed [7:0]  ks_c;
  logic signed [37:0] ls_c;
  logic [37:0]        als_c;
  logic [47:0]        p_ar;
  logic               p_rneg;
  logic [35:0]        p_als;
  logic               p_one;

  always_comb begin
    inv_c  = pd_st[PD_N].nq[48:0];
    rneg_c = inv_c > {17'd0, shape};
    ks_c   = $signed({1'b0, pn_st[NM_N].k}) - 8'sd24;
    ls_c   = $signed({ks_c, 30'd0}) + $signed({8'd0, ps_st[SQ_N].frac});
    als_c  = ls_c[37] ? 38'(-ls_c) : ls_c;
  end

  // Register the shape terms
  always_ff @(posedge clk) begin
    p_rneg <= rneg_c;
    p_ar   <= rneg_c ? 48'(inv_c - {17'd0, shape}) : 48'({17'd0, shape} - inv_c);
    p_als  <= als_c[35:0];
    p_one  <= (shape == lpe_pkg::SHAPE_ONE) || (ls_c == '0);
  end

  // Pipeline control
  logic           en;
  logic           sample_acc;
  logic [NST-1:0] vld;

  assign en           = !vld[NST-1] || result.ready;
  assign sample.ready = en && prep_done && !cfg.valid;
  assign sample_acc   = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], sample_acc};
    end
  end

  // Side data shift line
  lpe_pkg::tag_t tg  [0:NST-1];
  lpe_pkg::tag_t tgn [1:NST-1];
  lpe_pkg::tag_t tag0;

  // Entry stage: offset from the centre
  logic signed [32:0] d_c;
  logic [32:0]        ad_c;
  logic [31:0]        in_ad;

  always_comb begin
    d_c       = $signed({sample.abscissa[31], sample.abscissa}) -
                $signed({center[31], center});
    ad_c      = d_c[32] ? 33'(-d_c) : d_c;
    tag0      = '0;
    tag0.dneg = d_c[32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_ad <= ad_c[31:0];
      tg[0] <= tag0;
    end
  end

  // Offset over width
  lpe_pkg::div_st_t td_st [0:TD_N];

  assign td_st[0] = '{rem: '0, nq: {in_ad, 32'd0}};

  for (genvar j = 0; j < TD_N; j++) begin : g_tdiv
    lpe_div_cell u_cell (
      .clk(clk), .en(en), .divisor({4'd0, width}), .st_in(td_st[j]), .st_out(td_st[j+1])
    );
  end

  // Partial products of t and the shape term
  logic [55:0] t_c;
  logic [51:0] pp00;
  logic [51:0] pp01;
  logic [51:0] pp10;
  logic [51:0] pp11;

  assign t_c = td_st[TD_N].nq[55:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= {24'd0, t_c[27:0]}  * {28'd0, p_ar[23:0]};
      pp01 <= {24'd0, t_c[27:0]}  * {28'd0, p_ar[47:24]};
      pp10 <= {24'd0, t_c[55:28]} * {28'd0, p_ar[23:0]};
      pp11 <= {24'd0, t_c[55:28]} * {28'd0, p_ar[47:24]};
    end
  end

  // Sum the product and form u, or flag the cut-off
  logic [103:0] p_c;
  logic         opp_c;
  logic         cut_c;
  logic [104:0] u_c;
  logic [127:0] u_reg;

  always_comb begin
    p_c   = {52'd0, pp00} + {28'd0, pp01, 24'd0} + {24'd0, pp10, 28'd0} + {pp11, 52'd0};
    opp_c = tg[S_PB-1].dneg != p_rneg;
    cut_c = opp_c && (p_c[103:48] != '0);
    u_c   = opp_c ? (U_ONE - {1'b0, p_c}) : (U_ONE + {1'b0, p_c});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_reg <= {23'd0, u_c};
    end
  end

  // log2 u
  lpe_pkg::norm_st_t nm_st [0:NM_N];
  lpe_pkg::sq_st_t   sq_st [0:SQ_N];

  assign nm_st[0] = '{val: u_reg, k: 7'd127};
  assign sq_st[0] = '{m: nm_st[NM_N].val[127:97], frac: '0};

  for (genvar j = 0; j < NM_N; j++) begin : g_norm
    localparam logic [6:0] SH = 7'(64 >> j);
    lpe_norm_cell u_cell (
      .clk(clk), .en(en), .shamt(SH), .st_in(nm_st[j]), .st_out(nm_st[j+1])
    );
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sq
    lpe_sq_cell u_cell (.clk(clk), .en(en), .st_in(sq_st[j]), .st_out(sq_st[j+1]));
  end

  // Magnitude of log2 u and the range check of the ratio
  logic signed [7:0]  ku_c;
  logic signed [37:0] lu_c;
  logic [37:0]        alu_c;
  logic               sat_c;
  logic [37:0]        lg_alu;

  always_comb begin
    ku_c  = $signed({1'b0, tg[S_LG-1].k}) - 8'sd48;
    lu_c  = $signed({ku_c, 30'd0}) + $signed({8'd0, sq_st[SQ_N].frac});
    alu_c = lu_c[37] ? 38'(-lu_c) : lu_c;
    sat_c = {2'd0, alu_c} >= {p_als, 4'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg_alu <= alu_c;
    end
  end

  // Ratio of the logs, 28 quotient bits
  lpe_pkg::div_st_t rd_st [0:RD_N];

  assign rd_st[0] = '{rem: {2'd0, lg_alu[37:4]}, nq: {lg_alu[3:0], 60'd0}};

  for (genvar j = 0; j < RD_N; j++) begin : g_rdiv
    lpe_div_cell u_cell (
      .clk(clk), .en(en), .divisor(p_als), .st_in(rd_st[j]), .st_out(rd_st[j+1])
    );
  end

  // Pick R; symmetric shape uses twice t
  logic [27:0] r_c;
  logic        big_c;
  logic [27:0] r_reg;

  always_comb begin
    if (p_one) begin
      big_c = tg[S_RS-1].t[55:27] != '0;
      r_c   = {tg[S_RS-1].t[26:0], 1'b0};
    end else begin
      big_c = tg[S_RS-1].big;
      r_c   = rd_st[RD_N].nq[27:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_reg <= r_c;
    end
  end

  // Exponent q = R^2 in Q.32
  logic [55:0] rr_c;
  logic [39:0] q_reg;

  assign rr_c = {28'd0, r_reg} * {28'd0, r_reg};

  always_ff @(posedge clk) begin
    if (en) begin
      q_reg <= rr_c[55:16];
    end
  end

  // 2^-fraction
  lpe_pkg::exp_st_t ex_st [0:EX_N];

  assign ex_st[0] = '{g: 33'h1_0000_0000, f: q_reg[31:0]};

  for (genvar j = 0; j < EX_N; j++) begin : g_exp
    localparam logic [31:0] EXP_B = lpe_pkg::exp_b(j);
    lpe_exp_cell u_cell (
      .clk(clk), .en(en), .fac(EXP_B), .st_in(ex_st[j]), .st_out(ex_st[j+1])
    );
  end

  // Carry side data, updating fields where they are produced
  always_comb begin
    for (int s = 1; s < NST; s++) begin
      tgn[s] = tg[s-1];
    end
    tgn[S_PA].t    = t_c;
    tgn[S_PB].cut  = cut_c;
    tgn[S_SQ].k    = nm_st[NM_N].k;
    tgn[S_LG].big  = sat_c;
    tgn[S_RS].big  = big_c;
    tgn[S_EX].n    = q_reg[39:32];
    tgn[S_EX].zero = tg[S_EX-1].big || (q_reg[39:32] >= 8'd40);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 1; s < NST; s++) begin
        tg[s] <= tgn[s];
      end
    end
  end

  // Integer part of the exponent
  logic [32:0] g_reg;

  always_ff @(posedge clk) begin
    if (en) begin
      g_reg <= tg[S_GS-1].zero ? '0 : (ex_st[EX_N].g >> tg[S_GS-1].n[5:0]);
    end
  end

  // Scale by amplitude
  logic signed [65:0] prod_reg;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_reg <= $signed(amplitude) * $signed({1'b0, g_reg});
    end
  end

  // Add background, saturate, apply the special cases
  logic               bad_c;
  logic signed [34:0] sum_c;
  logic [31:0]        sat_val;
  logic [31:0]        value_c;
  logic [31:0]        out_value;
  logic               out_bad;

  always_comb begin
    bad_c = width[31] || (width == '0) || (shape == '0);
    sum_c = $signed({{3{background[31]}}, background}) +
            $signed({prod_reg[65], prod_reg[65:32]});
    if (sum_c > 35'sd2147483647) begin
      sat_val = 32'h7FFF_FFFF;
    end else if (sum_c < -35'sd2147483648) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = sum_c[31:0];
    end
    if (bad_c) begin
      value_c = '0;
    end else if (tg[S_OUT-1].cut) begin
      value_c = background;
    end else begin
      value_c = sat_val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= value_c;
      out_bad   <= bad_c;
    end
  end

  assign result.valid     = vld[NST-1];
  assign result.value     = out_value;
  assign result.bad_param = out_bad;

  // A configuration write closes the input for the following cycle
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (rst)
    cfg_acc |=> !sample.ready)
    else $error("input open right after a configuration write");

  // A stalled result freezes the row, so no new input is taken
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !sample.ready)
    else $error("input taken while the result is stalled");

  // Parameter errors report a zero value
  a_bad_gives_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.bad_param |-> result.value == '0)
    else $error("bad parameter result with nonzero value");

endmodule

@@ dv/tb_lognormal_peak_eval.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of lognormal_peak_eval: abscissas in, peak values out.
// Bit-exact predictor with its own register copy; depends on lpe_pkg and the three interfaces.
module tb_lognormal_peak_eval;

  localparam int CLK_HALF   = 5;
  localparam int SETTLE     = 240;
  localparam longint LIMIT  = 400000;
  localparam int HOLD_LEN   = 400;
  localparam int HOLD_AT    = 420;
  localparam logic [lpe_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
  localparam logic [lpe_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [31:0] value;
    logic               bad_param;
  } peak_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lpe_in_if  sample_if ();
  lpe_out_if result_if ();
  lpe_cfg_if cfg_if ();

  lognormal_peak_eval dut (
    .clk(clk), .rst(rst), .sample(sample_if.sink), .result(result_if.source), .cfg(cfg_if.sink)
  );

  // Register copy used by the predictor
  logic [31:0] amp_q = lpe_pkg::AMPLITUDE_RST;
  logic [31:0] ctr_q = lpe_pkg::CENTER_RST;
  logic [31:0] wid_q = lpe_pkg::WIDTH_RST;
  logic [31:0] shp_q = lpe_pkg::SHAPE_RST;
  logic [31:0] bkg_q = lpe_pkg::BACKGROUND_RST;

  logic signed [31:0] abscissa_q[$];
  peak_res_t          expected_q[$];
  longint cycles = 0;
  int     accepted = 0;
  int     received = 0;
  int     bad_seen = 0;
  int     mismatches = 0;
  int     phases = 0;
  bit     quiet = 1'b0;

  // Clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] rem, res, bitv;
    rem  = v;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // log2 of a nonzero value with pt fraction bits, result in Q.30
  function automatic longint log2_fix(input logic [127:0] v, input int pt);
    int          k;
    logic [63:0] m;
    logic [127:0] al;
    longint      frac;
    k = 0;
    for (int i = 127; i >= 0; i--) begin
      if (v[i] && k == 0) k = i;
    end
    al = (k >= 30) ? (v >> (k - 30)) : (v << (30 - k));
    m = {33'b0, al[30:0]};
    frac = 0;
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(k - pt) * 64'sd1073741824 + frac;
  endfunction

  // 2^-q, q and result in Q.32
  function automatic logic [63:0] pow2_neg(input logic [63:0] q);
    logic [63:0] n, g, b;
    n = q >> 32;
    g = 64'd1 << 32;
    b = 64'd1 << 31;
    for (int i = 31; i >= 0; i--) begin
      if (q[i]) g = (g * b) >> 32;
      b = int_root(b << 32);
    end
    return (n >= 40) ? 64'd0 : (g >> n);
  endfunction

  function automatic peak_res_t peak_value(input logic signed [31:0] x);
    peak_res_t      r;
    longint         dx, av, bv, sum, scaled, lu, ls;
    logic [63:0]    adist, tq, inv, ar, rr, g, mag, wv;
    logic [127:0]   prod, u;
    bit             dneg, rneg;
    r.bad_param = 1'b0;
    if ($signed(wid_q) <= 0 || shp_q == 0) begin
      r.value = '0;
      r.bad_param = 1'b1;
      return r;
    end
    dx = longint'(x) - longint'($signed(ctr_q));
    dneg = dx < 0;
    adist = dneg ? -dx : dx;
    wv = {32'b0, wid_q};
    tq = (adist << 24) / wv;
    if (shp_q == lpe_pkg::SHAPE_ONE) begin
      rr = 2 * tq;
    end else begin
      inv = (64'd1 << 48) / {32'b0, shp_q};
      rneg = inv > shp_q;
      ar = rneg ? inv - shp_q : shp_q - inv;
      prod = {64'b0, tq} * {64'b0, ar};
      if (dneg != rneg) begin
        // peak cut off: offset beyond the log-normal support
        if (prod >= (128'd1 << 48)) begin
          r.value = bkg_q;
          return r;
        end
        u = (128'd1 << 48) - prod;
      end else begin
        u = prod + (128'd1 << 48);
      end
      lu = log2_fix(u, 48);
      ls = log2_fix({96'b0, shp_q}, 24);
      if (ls == 0) rr = 2 * tq;
      else rr = ((lu < 0 ? -lu : lu) << 24) / (ls < 0 ? -ls : ls);
    end
    g = (rr >= (64'd16 << 24)) ? 64'd0 : pow2_neg((rr * rr) >> 16);
    av = longint'($signed(amp_q));
    if (av >= 0) begin
      mag = av * g;
      scaled = mag >> 32;
    end else begin
      mag = (-av) * g;
      scaled = -longint'((mag + 64'hFFFF_FFFF) >> 32);
    end
    bv = longint'($signed(bkg_q));
    sum = bv + scaled;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    r.value = sum[31:0];
    return r;
  endfunction

  // Sender: offer queued abscissas, idle at random outside the quiet stretch
  initial begin
    sample_if.valid = 1'b0;
    sample_if.abscissa = '0;
  end
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("lognormal_peak_eval: mismatch");
      $finish;
    end else if (!rst) begin
      if (sample_if.valid && sample_if.ready) begin
        expected_q.push_back(peak_value(sample_if.abscissa));
        accepted <= accepted + 1;
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (abscissa_q.size() != 0 && (quiet || $urandom_range(99) >= 28)) begin
          sample_if.valid <= 1'b1;
          sample_if.abscissa <= abscissa_q.pop_front();
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and the result check
  int hold_cnt = 0;
  bit held = 1'b0;
  initial result_if.ready = 1'b0;
  always @(posedge clk) begin
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        received <= received + 1;
        if (expected_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected result value=%0d bad=%0b", result_if.value, result_if.bad_param);
        end else begin
          peak_res_t e;
          e = expected_q.pop_front();
          if (e.bad_param) bad_seen <= bad_seen + 1;
          if (e.value != result_if.value || e.bad_param != result_if.bad_param) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("result %0d: expected value=%0d bad=%0b, got value=%0d bad=%0b",
                       received, e.value, e.bad_param, result_if.value, result_if.bad_param);
          end
        end
      end
      if (!held && accepted >= HOLD_AT) begin
        held <= 1'b1;
        hold_cnt <= HOLD_LEN;
        result_if.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        result_if.ready <= (hold_cnt == 1);
      end else begin
        result_if.ready <= quiet || ($urandom_range(99) >= 28);
      end
    end
  end

  // Configuration write; the register copy follows the transaction
  task automatic write_reg(input logic [lpe_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      lpe_pkg::REG_AMPLITUDE:  amp_q = data;
      lpe_pkg::REG_CENTER:     ctr_q = data;
      lpe_pkg::REG_WIDTH:      wid_q = data;
      lpe_pkg::REG_SHAPE:      shp_q = data;
      lpe_pkg::REG_BACKGROUND: bkg_q = data;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [31:0] a, c, w, s, b);
    write_reg(lpe_pkg::REG_AMPLITUDE, a);
    write_reg(lpe_pkg::REG_CENTER, c);
    write_reg(lpe_pkg::REG_WIDTH, w);
    write_reg(lpe_pkg::REG_SHAPE, s);
    write_reg(lpe_pkg::REG_BACKGROUND, b);
    phases++;
  endtask

  // Wait until every abscissa is sent and every result is back, then let the pipeline empty
  task automatic drain();
    do @(posedge clk);
    while (abscissa_q.size() != 0 || sample_if.valid || expected_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_shape();
    case ($urandom_range(5))
      0: return lpe_pkg::SHAPE_ONE;
      1: return lpe_pkg::SHAPE_ONE + $urandom_range(4095) - 2048;
      2: return $urandom;
      default: return $urandom_range(32'h0800_0000, 32'h0040_0000);
    endcase
  endfunction

  // Mostly points around the peak, some anywhere
  task automatic queue_random(input int n);
    longint w, off;
    for (int i = 0; i < n; i++) begin
      w = longint'($signed(wid_q));
      if (w <= 0 || w > 64'sd16777216) w = 64'sd65536;
      off = longint'($urandom_range(8000)) - 4000;
      if ($urandom_range(9) < 7)
        abscissa_q.push_back(32'(longint'($signed(ctr_q)) + (off * w) / 1000));
      else
        abscissa_q.push_back($urandom);
    end
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // Reset settings: field extremes
    abscissa_q = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd65536};
    drain();
    // Skewed peak, cut off on the low side
    set_all(32'h0064_0000, 32'h0001_0000, 32'h0002_0000, 32'h0200_0000, 32'h0005_0000);
    abscissa_q = '{32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 32'sh0010_0000};
    drain();
    // Skewed the other way, cut off on the high side, negative amplitude
    set_all(32'hFF00_0000, 32'h0000_0000, 32'h0001_0000, 32'h0080_0000, 32'h0000_0000);
    abscissa_q = '{32'sh0000_8000, 32'sh0004_0000, -32'sh0000_8000};
    drain();
    // Bad parameters: zero width, negative width, zero shape
    write_reg(lpe_pkg::REG_WIDTH, 32'h0);
    abscissa_q = '{32'sd0, 32'sd77};
    drain();
    write_reg(lpe_pkg::REG_WIDTH, 32'h8000_0000);
    abscissa_q = '{32'sd5};
    drain();
    set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
    abscissa_q = '{32'sd0};
    drain();
    // Saturation at both ends, extreme shapes
    set_all(32'h7FFF_FFFF, 32'h0000_0000, 32'h0001_0000, lpe_pkg::SHAPE_ONE, 32'h7FFF_FFFF);
    abscissa_q = '{32'sd0, 32'sd100};
    drain();
    set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h8000_0000);
    abscissa_q = '{32'sh7FFF_FFFF, 32'sh7FFF_FFF0};
    drain();
    set_all(32'h0001_0000, 32'h0000_0000, 32'h0100_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    abscissa_q = '{32'sh0010_0000, -32'sh0000_0100};
    drain();
    // Writes past the last register are dropped
    for (logic [lpe_pkg::CFG_IDX_W-1:0] i = IDX_SPARE_LO;
         i <= IDX_SPARE_HI && i >= IDX_SPARE_LO; i++)
      write_reg(i, $urandom);
    abscissa_q = '{32'sh0000_4000};
    drain();

    // Random settings, random points; one phase with no idling
    for (int p = 0; p < 14; p++) begin
      logic [31:0] w;
      w = ($urandom_range(7) == 0) ? $urandom : $urandom_range(32'h0040_0000, 32'h0000_1000);
      if ($urandom_range(15) == 0) w = 32'h0;
      set_all($urandom, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h00FF_FFFF),
              w, ($urandom_range(19) == 0) ? 32'h0 : rand_shape(), $urandom);
      quiet = (p == 6);
      queue_random(125);
      drain();
    end
    quiet = 1'b0;

    $display("covered %0d configuration phases, %0d abscissas, %0d results (%0d with bad params)",
             phases, accepted, received, bad_seen);
    $display("including a %0d-cycle result hold-off and saturating and cut-off cases", HOLD_LEN);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("lognormal_peak_eval: match");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("lognormal_peak_eval: mismatch");
    end
    $finish;
  end

endmodule
